/* src/sfq_pkg.sv */
package sfq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_MODIFY = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic    load_req;
        logic    ins_write;
        logic    idx_clear;
        logic    idx_inc;
        logic    rd_issue;
        logic    rd_next;
        logic    write_mod;
        logic    write_shift;
        logic    count_dec;
        logic    set_result;
        logic    res_found;
        status_t res_status;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  empty;
        logic  match;
        logic  last;
        logic  out_free;
    } sts_t;

endpackage

/* src/searchable_fifo_queue_unit.sv */
// insert and empty-queue requests go from dispatch straight to the response state; search,
// modify and remove scan entries from the head through the registered read port of the
// entry store, and remove then shifts each later entry toward the head. one request is
// in work at a time, and a new one is taken while the previous result waits on m_tready
// reset: rst_n clears the controller, the fill count and the output valid; the entry store
// is not cleared and needs no clearing pass
module searchable_fifo_queue_unit
    import sfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key_value [31:0], new_value [63:32]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // found [0], status [2:1], occupancy [7:3]
);

    cmd_t cmd;
    sts_t sts;

    sfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

/* src/sfq_ctrl.sv */
module sfq_ctrl
    import sfq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = STAT_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.set_result = 1'b1;
                state_next     = ST_RESP;
                if (sts.kind == KIND_INSERT)
                begin
                    if (sts.full)
                    begin
                        cmd.res_status = STAT_FULL;
                    end
                    else
                    begin
                        cmd.ins_write = 1'b1;
                    end
                end
                else if (sts.empty)
                begin
                    cmd.res_status = STAT_EMPTY;
                end
                else
                begin
                    cmd.set_result = 1'b0;
                    cmd.idx_clear  = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                if (sts.match)
                begin
                    if (sts.kind == KIND_REMOVE)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        cmd.write_mod  = (sts.kind == KIND_MODIFY);
                        cmd.set_result = 1'b1;
                        cmd.res_found  = 1'b1;
                        state_next     = ST_RESP;
                    end
                end
                else if (sts.last)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STAT_NOT_FOUND;
                    state_next     = ST_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_SHIFT_RD:
            begin
                if (sts.last)
                begin
                    cmd.count_dec  = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.res_found  = 1'b1;
                    state_next     = ST_RESP;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.rd_next  = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.write_shift = 1'b1;
                cmd.idx_inc     = 1'b1;
                state_next      = ST_SHIFT_RD;
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/sfq_datapath.sv */
module sfq_datapath
    import sfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    input  cmd_t        cmd,
    output sts_t        sts
);

    logic [VAL_W-1:0] mem [DEPTH];

    kind_t            kind_reg;
    logic [VAL_W-1:0] key_reg;
    logic [VAL_W-1:0] new_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic             res_found_reg;
    status_t          res_status_reg;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             wr_en;
    logic [CNT_W-1:0] idx_plus_one;

    assign idx_plus_one = CNT_W'(idx_reg) + CNT_W'(1);
    assign rd_addr      = cmd.rd_next ? IDX_W'(idx_plus_one) : idx_reg;
    assign wr_en        = cmd.ins_write | cmd.write_mod | cmd.write_shift;

    always_comb
    begin
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        if (cmd.ins_write)
        begin
            wr_addr = IDX_W'(count_reg);
            wr_data = key_reg;
        end
        else if (cmd.write_mod)
        begin
            wr_data = new_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg <= kind_t'(s_tuser);
            key_reg  <= s_tdata[31:0];
            new_reg  <= s_tdata[63:32];
        end
        if (cmd.set_result)
        begin
            res_found_reg  <= cmd.res_found;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {OCC_W'(count_reg), res_status_reg, res_found_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= IDX_W'(idx_plus_one);
            end
            if (cmd.ins_write)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.kind     = kind_reg;
    assign sts.full     = (count_reg == CNT_W'(DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.match    = (rd_data_reg == key_reg);
    assign sts.last     = (idx_plus_one >= count_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
